### rtl/mask_levels_gamma_defines.svh
// assertion macros for the levels and gamma pixel pipeline
`ifndef MASK_LEVELS_GAMMA_DEFINES_SVH
`define MASK_LEVELS_GAMMA_DEFINES_SVH

// same-cycle implication
`define MLG_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MLG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/mlg_pkg.sv
// package with constants, register codes and exp2 constant helpers
`timescale 1ns / 1ps

package mlg_pkg;

	localparam int LEVEL_FRAC_BITS_DEF = 16;
	localparam int CFG_W               = 17;
	localparam int GAMMA_W             = 16;
	localparam int CFG_IDX_W           = 3;
	localparam logic [GAMMA_W-1:0] GAMMA_UNIT = 16'd4096;
	localparam logic [GAMMA_W-1:0] GAMMA_MIN  = 16'd410;
	localparam logic [GAMMA_W-1:0] GAMMA_MAX  = 16'd40960;
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INVERT_SOURCE = 3'd0,
		CFG_IN_LOW        = 3'd1,
		CFG_IN_HIGH       = 3'd2,
		CFG_GAMMA         = 3'd3,
		CFG_OUT_LOW       = 3'd4,
		CFG_OUT_HIGH      = 3'd5,
		CFG_INVERT_RESULT = 3'd6
	} cfg_idx_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] b;
		rem = x;
		res = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// 2^(-2^-k) in q30
	function automatic logic [30:0] exp_const(input int k);
		logic [63:0] c;
		c = isqrt64(64'd1 << 59);
		for (int j = 1; j < k; j++) begin
			c = isqrt64(c << 30);
		end
		return c[30:0];
	endfunction

endpackage

### rtl/mask_levels_gamma.sv
// levels adjustment with gamma for 8-bit mask pixels, fully pipelined
//
// Slave side s_tvalid/s_tready/s_tdata carries one raw mask pixel per
// transaction; master side m_tvalid/m_tready/m_tdata/m_tuser returns the
// adjusted pixel and the settings error flag for each, in order.
// Settings must be written through cfg_we/cfg_index/cfg_data while the stream
// is quiet, but the block does not enforce it; they take effect on the next pixel.
// The pipeline has 97 register stages; one pixel per clock is sustained as long
// as the receiver does not stall the output by holding m_tready low.
// Stage budget: one input stage for the numerator and clamp flags,
// 30 restoring-divide steps for the level normalization,
// one normalize stage, 30 squaring steps for log2, one gamma multiply,
// 30 constant multiplies for exp2, one rounding shift and three output stages.
// All stages advance together; when the receiver stalls with a result
// waiting, s_tready drops and every stage holds, so nothing is lost.
// Reset clears all valid bits and loads the default settings: no inversion,
// full input and output range, gamma 1.0.
`timescale 1ns / 1ps
`include "mask_levels_gamma_defines.svh"

module mask_levels_gamma #(
	parameter int LEVEL_FRAC_BITS = mlg_pkg::LEVEL_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] pixel_in
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [7:0] pixel_out
	output logic                          m_tuser,   // [0] settings_error
	input  logic                          cfg_we,
	input  logic [mlg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mlg_pkg::CFG_W-1:0]     cfg_data
);

	localparam int F    = LEVEL_FRAC_BITS;
	localparam int LW   = (F + 1 > mlg_pkg::CFG_W) ? F + 1 : mlg_pkg::CFG_W;
	localparam int NUMW = LW + 9;
	localparam int DENW = LW + 8;
	localparam int HW   = (DENW > 30) ? DENW : 30;
	localparam int PW   = LW + 33;
	localparam int OVW  = PW + 1;
	localparam int OW   = F + 31;
	localparam int BW   = F + 39;
	localparam int NSTEP = 30;
	localparam int MIN_SPAN = ((1 << F) + 999) / 1000;
	localparam logic [LW:0]    ONE_L  = (LW + 1)'(1) << F;
	localparam logic [LW-1:0]  ONE_R  = LW'(1) << F;
	localparam logic [OVW-1:0] FULL_V = OVW'(1) << (F + 30);

	// settings
	logic                        invert_source_q;
	logic [LW-1:0]               in_low_q;
	logic [LW-1:0]               in_high_q;
	logic [mlg_pkg::GAMMA_W-1:0] gamma_q;
	logic [LW-1:0]               out_low_q;
	logic [LW-1:0]               out_high_q;
	logic                        invert_result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_source_q <= 1'b0;
			in_low_q        <= '0;
			in_high_q       <= ONE_R;
			gamma_q         <= mlg_pkg::GAMMA_UNIT;
			out_low_q       <= '0;
			out_high_q      <= ONE_R;
			invert_result_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (mlg_pkg::cfg_idx_t'(cfg_index))
				mlg_pkg::CFG_INVERT_SOURCE: invert_source_q <= cfg_data[0];
				mlg_pkg::CFG_IN_LOW:        in_low_q        <= LW'(cfg_data);
				mlg_pkg::CFG_IN_HIGH:       in_high_q       <= LW'(cfg_data);
				mlg_pkg::CFG_GAMMA:         gamma_q         <= cfg_data[mlg_pkg::GAMMA_W-1:0];
				mlg_pkg::CFG_OUT_LOW:       out_low_q       <= LW'(cfg_data);
				mlg_pkg::CFG_OUT_HIGH:      out_high_q      <= LW'(cfg_data);
				mlg_pkg::CFG_INVERT_RESULT: invert_result_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// values derived from settings, static while pixels flow
	logic            err_c;
	logic [LW-1:0]   span_c;
	logic [DENW-1:0] den_c;
	logic [HW-1:0]   hx_c;
	logic            gamma_on_c;

	always_comb begin
		err_c = ({1'b0, in_low_q} > ONE_L) || ({1'b0, in_high_q} > ONE_L) ||
			({1'b0, out_low_q} > ONE_L) || ({1'b0, out_high_q} > ONE_L) ||
			(gamma_q < mlg_pkg::GAMMA_MIN) || (gamma_q > mlg_pkg::GAMMA_MAX) ||
			({1'b0, in_high_q} < ({1'b0, in_low_q} + (LW + 1)'(MIN_SPAN)));
		span_c     = in_high_q - in_low_q;
		den_c      = DENW'(span_c) * DENW'(255);
		hx_c       = HW'(den_c >> 1);
		gamma_on_c = (gamma_q != mlg_pkg::GAMMA_UNIT);
	end

	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// stage 1: numerator and clamp flags
	logic [7:0]      q_c;
	logic [NUMW-1:0] num_c;
	logic            zero_c;
	logic            one_c;

	always_comb begin
		q_c    = invert_source_q ? (8'd255 - s_tdata) : s_tdata;
		num_c  = (NUMW'(q_c) << F) - (NUMW'(in_low_q) * NUMW'(255));
		zero_c = num_c[NUMW-1] || (num_c == '0);
		one_c  = !num_c[NUMW-1] && (num_c >= NUMW'(den_c));
	end

	// divide section: s1..s31
	logic [NSTEP:0]  div_v_s;
	logic [NSTEP:0]  div_err_s;
	logic [NSTEP:0]  div_zero_s;
	logic [NSTEP:0]  div_one_s;
	logic [DENW-1:0] div_rem_s [0:NSTEP];
	logic [29:0]     div_quo_s [0:NSTEP];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s[0] <= 1'b0;
		end else if (adv) begin
			div_v_s[0] <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_err_s[0]  <= err_c;
			div_zero_s[0] <= zero_c;
			div_one_s[0]  <= one_c;
			div_rem_s[0]  <= num_c[DENW-1:0];
			div_quo_s[0]  <= '0;
		end
	end

	for (genvar i = 0; i < NSTEP; i++) begin : g_div
		logic [DENW:0] rem2;
		logic          ge;

		always_comb begin
			rem2 = {div_rem_s[i], hx_c[29-i]};
			ge   = (rem2 >= {1'b0, den_c});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[i+1] <= 1'b0;
			end else if (adv) begin
				div_v_s[i+1] <= div_v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_err_s[i+1]  <= div_err_s[i];
				div_zero_s[i+1] <= div_zero_s[i];
				div_one_s[i+1]  <= div_one_s[i];
				div_rem_s[i+1]  <= ge ? DENW'(rem2 - {1'b0, den_c}) : DENW'(rem2);
				div_quo_s[i+1]  <= {div_quo_s[i][28:0], ge};
			end
		end
	end

	// normalize the quotient for log2
	logic [30:0] lvl_c;
	logic        gen_c;
	logic [30:0] nx_c;
	logic [4:0]  ns_c;

	always_comb begin
		if (div_zero_s[NSTEP]) begin
			lvl_c = '0;
		end else if (div_one_s[NSTEP]) begin
			lvl_c = mlg_pkg::Q30_ONE;
		end else begin
			lvl_c = {1'b0, div_quo_s[NSTEP]};
		end
		gen_c = !div_err_s[NSTEP] && !div_zero_s[NSTEP] && !div_one_s[NSTEP] && gamma_on_c;
		nx_c  = {1'b0, div_quo_s[NSTEP]};
		ns_c  = '0;
		if (nx_c[30:15] == '0) begin
			nx_c = nx_c << 16;
			ns_c = ns_c + 5'd16;
		end
		if (nx_c[30:23] == '0) begin
			nx_c = nx_c << 8;
			ns_c = ns_c + 5'd8;
		end
		if (nx_c[30:27] == '0) begin
			nx_c = nx_c << 4;
			ns_c = ns_c + 5'd4;
		end
		if (nx_c[30:29] == '0) begin
			nx_c = nx_c << 2;
			ns_c = ns_c + 5'd2;
		end
		if (!nx_c[30]) begin
			nx_c = nx_c << 1;
			ns_c = ns_c + 5'd1;
		end
	end

	// log2 section: s32..s62
	logic [NSTEP:0] lg_v_s;
	logic [NSTEP:0] lg_err_s;
	logic [NSTEP:0] lg_gen_s;
	logic [30:0]    lg_lvl_s [0:NSTEP];
	logic [30:0]    lg_m_s   [0:NSTEP];
	logic [29:0]    lg_fr_s  [0:NSTEP];
	logic [4:0]     lg_sh_s  [0:NSTEP];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_v_s[0] <= 1'b0;
		end else if (adv) begin
			lg_v_s[0] <= div_v_s[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lg_err_s[0] <= div_err_s[NSTEP];
			lg_gen_s[0] <= gen_c;
			lg_lvl_s[0] <= lvl_c;
			lg_m_s[0]   <= nx_c;
			lg_fr_s[0]  <= '0;
			lg_sh_s[0]  <= ns_c;
		end
	end

	for (genvar k = 1; k <= NSTEP; k++) begin : g_log
		logic [61:0] sq;
		logic [31:0] p;
		logic [29:0] fr_n;

		always_comb begin
			sq   = 62'(lg_m_s[k-1]) * 62'(lg_m_s[k-1]);
			p    = sq[61:30];
			fr_n = lg_fr_s[k-1];
			fr_n[30-k] = p[31];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lg_v_s[k] <= 1'b0;
			end else if (adv) begin
				lg_v_s[k] <= lg_v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				lg_err_s[k] <= lg_err_s[k-1];
				lg_gen_s[k] <= lg_gen_s[k-1];
				lg_lvl_s[k] <= lg_lvl_s[k-1];
				lg_m_s[k]   <= p[31] ? p[31:1] : p[30:0];
				lg_fr_s[k]  <= fr_n;
				lg_sh_s[k]  <= lg_sh_s[k-1];
			end
		end
	end

	// scale |log2| by gamma
	logic [34:0] t_c;
	logic [51:0] tg_c;

	always_comb begin
		t_c  = {lg_sh_s[NSTEP], 30'b0} - {5'b0, lg_fr_s[NSTEP]};
		tg_c = (52'(t_c) * 52'(gamma_q)) + 52'd2048;
	end

	// exp2 section: s63..s93
	logic [NSTEP:0] ex_v_s;
	logic [NSTEP:0] ex_err_s;
	logic [NSTEP:0] ex_gen_s;
	logic [30:0]    ex_lvl_s [0:NSTEP];
	logic [8:0]     ex_n_s   [0:NSTEP];
	logic [29:0]    ex_f_s   [0:NSTEP];
	logic [30:0]    ex_r_s   [0:NSTEP];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ex_v_s[0] <= 1'b0;
		end else if (adv) begin
			ex_v_s[0] <= lg_v_s[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ex_err_s[0] <= lg_err_s[NSTEP];
			ex_gen_s[0] <= lg_gen_s[NSTEP];
			ex_lvl_s[0] <= lg_lvl_s[NSTEP];
			ex_n_s[0]   <= tg_c[50:42];
			ex_f_s[0]   <= tg_c[41:12];
			ex_r_s[0]   <= mlg_pkg::Q30_ONE;
		end
	end

	for (genvar k = 1; k <= NSTEP; k++) begin : g_exp
		localparam logic [30:0] CK = mlg_pkg::exp_const(k);
		logic [61:0] pr;

		assign pr = 62'(ex_r_s[k-1]) * 62'(CK);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ex_v_s[k] <= 1'b0;
			end else if (adv) begin
				ex_v_s[k] <= ex_v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ex_err_s[k] <= ex_err_s[k-1];
				ex_gen_s[k] <= ex_gen_s[k-1];
				ex_lvl_s[k] <= ex_lvl_s[k-1];
				ex_n_s[k]   <= ex_n_s[k-1];
				ex_f_s[k]   <= ex_f_s[k-1];
				ex_r_s[k]   <= ex_f_s[k-1][30-k] ? pr[60:30] : ex_r_s[k-1];
			end
		end
	end

	// integer part of the exponent: rounding right shift
	logic [4:0]  n5_c;
	logic [31:0] rsum_c;
	logic [31:0] rsh_c;
	logic [30:0] glvl_c;

	always_comb begin
		n5_c   = ex_n_s[NSTEP][4:0];
		rsum_c = {1'b0, ex_r_s[NSTEP]} + ((32'd1 << n5_c) >> 1);
		rsh_c  = rsum_c >> n5_c;
		if (!ex_gen_s[NSTEP]) begin
			glvl_c = ex_lvl_s[NSTEP];
		end else if (ex_n_s[NSTEP] > 9'd30) begin
			glvl_c = '0;
		end else begin
			glvl_c = rsh_c[30:0];
		end
	end

	logic          v_s94, err_s94;
	logic [30:0]   lvl_s94;
	logic          v_s95, err_s95;
	logic [PW-1:0] prod_s95;
	logic          v_s96, err_s96;
	logic [OW-1:0] o_s96;
	logic          v_s97, err_s97;
	logic [7:0]    pix_s97;

	// output level mapping
	logic signed [LW:0]     odiff_c;
	logic signed [31:0]     lsx_c;
	logic signed [OVW-1:0]  ov_c;
	logic [OVW-1:0]         oc_c;
	logic [OW-1:0]          oi_c;
	logic [BW-1:0]          bsum_c;

	always_comb begin
		odiff_c = signed'({1'b0, out_high_q}) - signed'({1'b0, out_low_q});
		lsx_c   = signed'({1'b0, lvl_s94});
		ov_c    = signed'(OVW'(out_low_q) << 30) + OVW'(signed'(prod_s95));
		if (ov_c < 0) begin
			oc_c = '0;
		end else if (unsigned'(ov_c) > FULL_V) begin
			oc_c = FULL_V;
		end else begin
			oc_c = unsigned'(ov_c);
		end
		oi_c   = invert_result_q ? OW'(FULL_V - oc_c) : OW'(oc_c);
		bsum_c = (BW'(o_s96) << 8) - BW'(o_s96) + (BW'(1) << (F + 29));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s94 <= 1'b0;
			v_s95 <= 1'b0;
			v_s96 <= 1'b0;
			v_s97 <= 1'b0;
		end else if (adv) begin
			v_s94 <= ex_v_s[NSTEP];
			v_s95 <= v_s94;
			v_s96 <= v_s95;
			v_s97 <= v_s96;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s94  <= ex_err_s[NSTEP];
			lvl_s94  <= glvl_c;
			err_s95  <= err_s94;
			prod_s95 <= PW'(odiff_c) * PW'(lsx_c);
			err_s96  <= err_s95;
			o_s96    <= oi_c;
			err_s97  <= err_s96;
			pix_s97  <= err_s96 ? 8'd0 : bsum_c[F+30 +: 8];
		end
	end

	assign m_tvalid = v_s97;
	assign m_tdata  = pix_s97;
	assign m_tuser  = err_s97;

	`MLG_ASSERT_SAME(a_err_pixel_zero, m_tvalid && m_tuser, m_tdata == 8'd0,
		"settings error result carries a nonzero pixel")
	`MLG_ASSERT_NEXT(a_stall_freezes_pipe, !s_tready,
		$stable(div_v_s) && $stable(lg_v_s) && $stable(ex_v_s),
		"pipeline moved while the output was stalled")
	`MLG_ASSERT_SAME(a_gamma_only_valid, lg_v_s[0] && lg_gen_s[0],
		!lg_err_s[0] && gamma_on_c,
		"gamma path taken for an item that should bypass it")

endmodule

### bench/mask_levels_gamma_tb.sv
// testbench for the levels and gamma mask pixel pipeline, self-checking
`timescale 1ns / 1ps

class levels_scoreboard;
	typedef struct {
		bit [7:0] pixel;
		bit       err;
	} pix_result_t;

	pix_result_t expected_q[$];
	int unsigned errors;
	int unsigned checked;
	int unsigned error_results;

	// current settings as held by the block
	bit        inv_src, inv_res;
	bit [16:0] lvl_in_lo, lvl_in_hi, lvl_out_lo, lvl_out_hi;
	bit [15:0] gamma;

	// 2^(-2^-k) in q30 for k = 1..30
	bit [63:0] halving_pow[31];

	function new();
		inv_src    = 1'b0;
		inv_res    = 1'b0;
		lvl_in_lo  = '0;
		lvl_in_hi  = 17'd65536;
		gamma      = 16'd4096;
		lvl_out_lo = '0;
		lvl_out_hi = 17'd65536;
		halving_pow[1] = floor_sqrt(64'd1 << 59);
		for (int k = 2; k <= 30; k++)
			halving_pow[k] = floor_sqrt(halving_pow[k-1] << 30);
	endfunction

	function bit [63:0] floor_sqrt(bit [63:0] x);
		bit [63:0] r, t;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= x)
				r = t;
		end
		return r;
	endfunction

	function void set_reg(mlg_pkg::cfg_idx_t idx, bit [16:0] v);
		case (idx)
			mlg_pkg::CFG_INVERT_SOURCE: inv_src = v[0];
			mlg_pkg::CFG_IN_LOW:        lvl_in_lo = v;
			mlg_pkg::CFG_IN_HIGH:       lvl_in_hi = v;
			mlg_pkg::CFG_GAMMA:         gamma = v[15:0];
			mlg_pkg::CFG_OUT_LOW:       lvl_out_lo = v;
			mlg_pkg::CFG_OUT_HIGH:      lvl_out_hi = v;
			mlg_pkg::CFG_INVERT_RESULT: inv_res = v[0];
			default: ;
		endcase
	endfunction

	// level in q30 raised to gamma/4096 via log2 and exp2
	function bit [63:0] raise_gamma(bit [63:0] lvl);
		int        msb;
		bit [63:0] m, fr, t, tg, n, e;
		msb = 29;
		fr  = '0;
		while (msb > 0 && lvl[msb] == 0)
			msb--;
		m = lvl << (30 - msb);
		for (int i = 1; i <= 30; i++) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				fr |= 64'd1 << (30 - i);
			end
		end
		t  = (64'(30 - msb) << 30) - fr;
		tg = (t * 64'(gamma) + 64'd2048) >> 12;
		n  = tg >> 30;
		if (n > 30)
			return 64'd0;
		e = 64'd1 << 30;
		for (int k = 1; k <= 30; k++)
			if (tg[30-k])
				e = (e * halving_pow[k]) >> 30;
		if (n == 0)
			return e;
		return (e + (64'd1 << (n - 1))) >> n;
	endfunction

	function pix_result_t map_pixel(bit [7:0] p);
		pix_result_t res;
		bit [63:0]   q, lvl, o, full;
		longint      num, den, ov;
		if (lvl_in_lo > 65536 || lvl_in_hi > 65536 || lvl_out_lo > 65536 ||
				lvl_out_hi > 65536 || gamma < 410 || gamma > 40960 ||
				32'(lvl_in_hi) < 32'(lvl_in_lo) + 66) begin
			res.pixel = 8'd0;
			res.err   = 1'b1;
			return res;
		end
		q   = inv_src ? 64'(255 - p) : 64'(p);
		num = longint'(q * 65536) - longint'(255 * 64'(lvl_in_lo));
		den = 255 * (longint'(lvl_in_hi) - longint'(lvl_in_lo));
		if (num <= 0)
			lvl = '0;
		else if (num >= den)
			lvl = 64'd1 << 30;
		else
			lvl = (64'(num) * (64'd1 << 30) + 64'(den) / 2) / 64'(den);
		if (gamma != 16'd4096 && lvl != 0 && lvl != (64'd1 << 30))
			lvl = raise_gamma(lvl);
		full = 64'd1 << 46;
		ov = longint'(64'(lvl_out_lo) << 30) +
			(longint'(lvl_out_hi) - longint'(lvl_out_lo)) * longint'(lvl);
		if (ov < 0)
			ov = '0;
		if (ov > longint'(full))
			ov = longint'(full);
		o = 64'(ov);
		if (inv_res)
			o = full - o;
		res.pixel = 8'((255 * o + (64'd1 << 45)) >> 46);
		res.err   = 1'b0;
		return res;
	endfunction

	function void note_pixel(bit [7:0] p);
		expected_q.insert(expected_q.size(), map_pixel(p));
	endfunction

	function void check_result(bit [7:0] pix, bit err);
		pix_result_t exp_r;
		checked++;
		if (expected_q.size() == 0) begin
			$error("unexpected result pixel_out=%0d settings_error=%0d", pix, err);
			errors++;
			return;
		end
		exp_r = expected_q.pop_front();
		if (exp_r.err)
			error_results++;
		if (pix !== exp_r.pixel) begin
			$error("pixel_out expected %0d actual %0d", exp_r.pixel, pix);
			errors++;
		end
		if (err !== exp_r.err) begin
			$error("settings_error expected %0d actual %0d", exp_r.err, err);
			errors++;
		end
	endfunction
endclass

module mask_levels_gamma_tb;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [7:0]                    s_tdata;   // [7:0] pixel_in
	logic                          m_tvalid;
	logic                          m_tready;
	logic [7:0]                    m_tdata;   // [7:0] pixel_out
	logic                          m_tuser;   // [0] settings_error
	logic                          cfg_we;
	logic [mlg_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mlg_pkg::CFG_W-1:0]     cfg_data;

	levels_scoreboard levels_sb;
	bit               no_idle;
	int unsigned      phases_run;

	mask_levels_gamma dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	// writes every setting back to back, lowering the enable only at the end
	task automatic load_settings(bit isrc, bit [16:0] ilo, bit [16:0] ihi, bit [15:0] g,
			bit [16:0] olo, bit [16:0] ohi, bit ires);
		bit [16:0] vals[7];
		vals = '{17'(isrc), ilo, ihi, 17'(g), olo, ohi, 17'(ires)};
		for (int i = 0; i < 7; i++) begin
			cfg_we    <= 1;
			cfg_index <= mlg_pkg::cfg_idx_t'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			levels_sb.set_reg(mlg_pkg::cfg_idx_t'(i), vals[i]);
		end
		cfg_we <= 0;
		phases_run++;
	endtask

	task automatic send_pixel(bit [7:0] p);
		while (!no_idle && $urandom_range(0, 99) < 8) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata  <= p;
		do @(posedge clk); while (!s_tready);
		levels_sb.note_pixel(p);
	endtask

	task automatic drain_pipeline();
		s_tvalid <= 0;
		@(posedge clk);
		while (levels_sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic bit [7:0] pick_pixel();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic random_settings(bit allow_bad);
		bit [16:0] ilo, ihi, olo, ohi;
		bit [15:0] g;
		ilo = 17'($urandom_range(0, 65536 - 66));
		if ($urandom_range(0, 5) == 0)
			ihi = 17'(ilo + 66 + $urandom_range(0, 200));
		else
			ihi = 17'($urandom_range(ilo + 66, 65536));
		case ($urandom_range(0, 4))
			0: g = 16'd4096;
			1: g = 16'($urandom_range(410, 4096));
			default: g = 16'($urandom_range(410, 40960));
		endcase
		olo = 17'($urandom_range(0, 65536));
		ohi = 17'($urandom_range(0, 65536));
		if (allow_bad) begin
			case ($urandom_range(0, 3))
				0: ihi = 17'(ilo + $urandom_range(0, 65));
				1: g = 16'($urandom_range(0, 409));
				2: olo = 17'($urandom_range(65537, 131071));
				default: ilo = 17'($urandom_range(0, 131071));
			endcase
		end
		load_settings(1'($urandom_range(0, 1)), ilo, ihi, g, olo, ohi,
			1'($urandom_range(0, 1)));
	endtask

	// receiver: random backpressure plus one long hold once the pipeline is busy
	initial begin
		int unsigned held;
		m_tready <= 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			if (levels_sb.checked == 300 && held == 0) begin
				m_tready <= 0;
				for (held = 0; held < 400; held++)
					@(posedge clk);
			end
			m_tready <= no_idle || ($urandom_range(0, 99) >= 8);
			@(posedge clk);
			if (m_tvalid && m_tready)
				levels_sb.check_result(m_tdata, m_tuser);
		end
	end

	initial begin
		bit [7:0] edge_pix[8];
		bit [7:0] tri_pix[3];
		levels_sb  = new();
		edge_pix   = '{8'd0, 8'd1, 8'd2, 8'd127, 8'd128, 8'd253, 8'd254, 8'd255};
		tri_pix    = '{8'd0, 8'd128, 8'd255};
		arst_n     = 0;
		s_tvalid   = 0;
		s_tdata    = 0;
		cfg_we     = 0;
		cfg_index  = mlg_pkg::CFG_INVERT_SOURCE;
		cfg_data   = 0;
		no_idle    = 0;
		phases_run = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset settings: identity mapping
		foreach (edge_pix[i])
			send_pixel(edge_pix[i]);
		drain_pipeline();

		// both inversions with the smallest gamma
		load_settings(1'b1, 17'd0, 17'd65536, 16'd410, 17'd0, 17'd65536, 1'b1);
		foreach (tri_pix[i]) send_pixel(tri_pix[i]);
		drain_pipeline();
		// largest gamma on the narrowest legal span
		load_settings(1'b0, 17'd30000, 17'd30066, 16'd40960, 17'd0, 17'd65536, 1'b0);
		foreach (tri_pix[i]) send_pixel(tri_pix[i] == 128 ? 8'd117 : tri_pix[i]);
		drain_pipeline();
		// span one unit too narrow
		load_settings(1'b0, 17'd30000, 17'd30065, 16'd4096, 17'd0, 17'd65536, 1'b0);
		foreach (tri_pix[i]) send_pixel(tri_pix[i]);
		drain_pipeline();
		// all register bits high: out of range everywhere
		load_settings(1'b1, 17'h1FFFF, 17'h1FFFF, 16'hFFFF, 17'h1FFFF, 17'h1FFFF, 1'b1);
		foreach (tri_pix[i]) send_pixel(tri_pix[i]);
		drain_pipeline();
		// reversed output range with gamma just off unity
		load_settings(1'b0, 17'd1000, 17'd65536, 16'd4097, 17'd65536, 17'd0, 1'b0);
		foreach (tri_pix[i]) send_pixel(tri_pix[i]);
		drain_pipeline();

		for (int ph = 0; ph < 10; ph++) begin
			random_settings(ph == 7);
			no_idle = (ph == 5);
			for (int n = 0; n < 90; n++)
				send_pixel(pick_pixel());
			drain_pipeline();
			no_idle = 0;
		end

		repeat (120) @(posedge clk);
		$display("covered %0d results over %0d settings phases, %0d with a settings error",
			levels_sb.checked, phases_run, levels_sb.error_results);
		$display("including a long output stall that backed up the pipeline");
		if (levels_sb.errors == 0 && levels_sb.expected_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

### mask_levels_gamma.f
+incdir+rtl
rtl/mlg_pkg.sv
rtl/mask_levels_gamma.sv
bench/mask_levels_gamma_tb.sv
